FILE: design/ltehdd_pkg.sv
package ltehdd_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int MODE_W       = 3;
  localparam int Q16_STEP_W   = 15;
  localparam int Q64_STEP_W   = 14;
  localparam int Q256_STEP_W  = 13;
  localparam int CFG_DATA_W   = 15;
  localparam int CFG_IDX_W    = 2;
  localparam int BITS_W       = 8;
  localparam int COUNT_W      = 4;
  localparam int AMP_W        = 3;
  // compare width: covers |sample| and 7 * max 256QAM step
  localparam int CMP_W        = (SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH : 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_BPSK   = 3'd0,
    MODE_QPSK   = 3'd1,
    MODE_QAM16  = 3'd2,
    MODE_QAM64  = 3'd3,
    MODE_QAM256 = 3'd4
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE     = 2'd0,
    CFG_Q16_STEP = 2'd1,
    CFG_Q64_STEP = 2'd2,
    CFG_Q256_STEP = 2'd3
  } cfg_idx_e;

  localparam logic [MODE_W-1:0]      MODE_RST      = 3'd1;
  localparam logic [Q16_STEP_W-1:0]  Q16_STEP_RST  = 15'd5181;
  localparam logic [Q64_STEP_W-1:0]  Q64_STEP_RST  = 14'd2528;
  localparam logic [Q256_STEP_W-1:0] Q256_STEP_RST = 13'd1256;

  // Gray amplitude bits per region index
  localparam logic [1:0] AMP64_MAP [4] = '{2'd2, 2'd0, 2'd1, 2'd3};
  localparam logic [2:0] AMP256_MAP [8] = '{3'd0, 3'd2, 3'd6, 3'd4, 3'd5, 3'd1, 3'd3, 3'd7};

endpackage

FILE: design/ltehdd_sym_if.sv
interface ltehdd_sym_if;
  import ltehdd_pkg::*;

  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] in_i;
  logic signed [SAMPLE_WIDTH-1:0] in_q;
  logic                           end_of_block;

  modport source (output valid, output in_i, output in_q, output end_of_block, input ready);
  modport sink   (input valid, input in_i, input in_q, input end_of_block, output ready);
endinterface

FILE: design/ltehdd_res_if.sv
interface ltehdd_res_if;
  import ltehdd_pkg::*;

  logic               valid;
  logic               ready;
  logic [BITS_W-1:0]  bits;
  logic [COUNT_W-1:0] bit_count;
  logic               end_of_block_out;

  modport source (output valid, output bits, output bit_count, output end_of_block_out,
                  input ready);
  modport sink   (input valid, input bits, input bit_count, input end_of_block_out,
                  output ready);
endinterface

FILE: design/ltehdd_slicer.sv
module ltehdd_slicer import ltehdd_pkg::*; (
  input  logic signed [SAMPLE_WIDTH-1:0] comp_i,
  input  mode_e                          mode_i,
  input  logic [Q16_STEP_W-1:0]          q16_step_i,
  input  logic [Q64_STEP_W-1:0]          q64_step_i,
  input  logic [Q256_STEP_W-1:0]         q256_step_i,
  output logic                           sign_o,
  output logic [AMP_W-1:0]               amp_o
);

  logic [SAMPLE_WIDTH-1:0] comp_u;
  logic [SAMPLE_WIDTH-1:0] mag;
  logic [CMP_W-1:0]        mag_x;
  logic                    r16;
  logic [1:0]              r64;
  logic [2:0]              r256;

  assign comp_u = comp_i;
  assign mag    = comp_u[SAMPLE_WIDTH-1] ? (~comp_u + 1'b1) : comp_u;
  assign mag_x  = CMP_W'(mag);
  assign sign_o = comp_u[SAMPLE_WIDTH-1] | (comp_u == '0);

  // thresholds are monotone in k, so counting exceeded ones gives the region
  always_comb begin
    r16 = mag_x > CMP_W'(q16_step_i);
    r64 = '0;
    for (int k = 1; k <= 3; k++) begin
      if (mag_x > CMP_W'(CMP_W'(k) * CMP_W'(q64_step_i))) begin
        r64 = r64 + 2'd1;
      end
    end
    r256 = '0;
    for (int k = 1; k <= 7; k++) begin
      if (mag_x > CMP_W'(CMP_W'(k) * CMP_W'(q256_step_i))) begin
        r256 = r256 + 3'd1;
      end
    end
  end

  always_comb begin
    case (mode_i)
      MODE_BPSK:  amp_o = '0;
      MODE_QPSK:  amp_o = '0;
      MODE_QAM16: amp_o = {2'b00, r16};
      MODE_QAM64: amp_o = {1'b0, AMP64_MAP[r64]};
      default:    amp_o = AMP256_MAP[r256];
    endcase
  end

endmodule

FILE: design/lte_hard_decision_demapper_core.sv
// Hard-decision QAM demapper, BPSK through 256QAM.
// Registers: input reg, then result reg; the slicers sit between the two registers.
// Throughput: one item per cycle, stalled while a result waits with res_o.ready low.
// Reset (async, active low): pipeline emptied, mode QPSK, steps at nominal values.
module lte_hard_decision_demapper_core import ltehdd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  ltehdd_sym_if.sink            sym_i,
  ltehdd_res_if.source          res_o
);

  logic [MODE_W-1:0]      mode_q;
  logic [Q16_STEP_W-1:0]  q16_step_q;
  logic [Q64_STEP_W-1:0]  q64_step_q;
  logic [Q256_STEP_W-1:0] q256_step_q;
  mode_e                  mode;

  logic                           in_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] in_i_q;
  logic signed [SAMPLE_WIDTH-1:0] in_q_q;
  logic                           eob_q;

  logic               res_valid_q;
  logic [BITS_W-1:0]  bits_q;
  logic [COUNT_W-1:0] count_q;
  logic               eob_res_q;

  logic               in_adv;
  logic               res_free;
  logic               sign_i;
  logic               sign_q;
  logic [AMP_W-1:0]   amp_i;
  logic [AMP_W-1:0]   amp_q;
  logic signed [SAMPLE_WIDTH:0] sum;
  logic               bpsk_bit;
  logic [BITS_W-1:0]  bits_d;
  logic [COUNT_W-1:0] count_d;

  assign mode = mode_e'(mode_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_RST;
      q16_step_q  <= Q16_STEP_RST;
      q64_step_q  <= Q64_STEP_RST;
      q256_step_q <= Q256_STEP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MODE:      mode_q      <= cfg_data_i[MODE_W-1:0];
        CFG_Q16_STEP:  q16_step_q  <= cfg_data_i[Q16_STEP_W-1:0];
        CFG_Q64_STEP:  q64_step_q  <= cfg_data_i[Q64_STEP_W-1:0];
        CFG_Q256_STEP: q256_step_q <= cfg_data_i[Q256_STEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign res_free    = !res_valid_q || res_o.ready;
  assign in_adv      = in_valid_q && res_free;
  assign sym_i.ready = !in_valid_q || res_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (sym_i.ready) begin
      in_valid_q <= sym_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sym_i.valid && sym_i.ready) begin
      in_i_q <= sym_i.in_i;
      in_q_q <= sym_i.in_q;
      eob_q  <= sym_i.end_of_block;
    end
  end

  ltehdd_slicer u_slicer_i (
    .comp_i      (in_i_q),
    .mode_i      (mode),
    .q16_step_i  (q16_step_q),
    .q64_step_i  (q64_step_q),
    .q256_step_i (q256_step_q),
    .sign_o      (sign_i),
    .amp_o       (amp_i)
  );

  ltehdd_slicer u_slicer_q (
    .comp_i      (in_q_q),
    .mode_i      (mode),
    .q16_step_i  (q16_step_q),
    .q64_step_i  (q64_step_q),
    .q256_step_i (q256_step_q),
    .sign_o      (sign_q),
    .amp_o       (amp_q)
  );

  // BPSK: 1 when I+Q < 0, tie at zero gives 1 only for I > 0
  assign sum      = {in_i_q[SAMPLE_WIDTH-1], in_i_q} + {in_q_q[SAMPLE_WIDTH-1], in_q_q};
  assign bpsk_bit = sum[SAMPLE_WIDTH] ||
                    ((sum == '0) && !in_i_q[SAMPLE_WIDTH-1] && (in_i_q != '0));

  always_comb begin
    case (mode)
      MODE_BPSK: begin
        bits_d  = {7'b0, bpsk_bit};
        count_d = 4'd1;
      end
      MODE_QPSK: begin
        bits_d  = {6'b0, sign_q, sign_i};
        count_d = 4'd2;
      end
      MODE_QAM16: begin
        bits_d  = {amp_q[2], amp_i[2], amp_q[1], amp_i[1], amp_q[0], amp_i[0], sign_q, sign_i};
        count_d = 4'd4;
      end
      MODE_QAM64: begin
        bits_d  = {amp_q[2], amp_i[2], amp_q[1], amp_i[1], amp_q[0], amp_i[0], sign_q, sign_i};
        count_d = 4'd6;
      end
      default: begin
        bits_d  = {amp_q[2], amp_i[2], amp_q[1], amp_i[1], amp_q[0], amp_i[0], sign_q, sign_i};
        count_d = 4'd8;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_free) begin
      res_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv) begin
      bits_q    <= bits_d;
      count_q   <= count_d;
      eob_res_q <= eob_q;
    end
  end

  assign res_o.valid            = res_valid_q;
  assign res_o.bits             = bits_q;
  assign res_o.bit_count        = count_q;
  assign res_o.end_of_block_out = eob_res_q;

`ifndef SYNTHESIS
  a_unused_bits_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> ((bits_q >> count_q) == '0))
    else $error("result bits set above bit_count");

  a_item_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_adv |=> res_valid_q)
    else $error("item lost between input and result register");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && res_valid_q && !res_o.ready) |-> !sym_i.ready)
    else $error("item accepted while pipeline is full and stalled");
`endif

endmodule

FILE: verif/lte_hard_decision_demapper_core_tb.sv
module lte_hard_decision_demapper_core_tb;
  import ltehdd_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;
  localparam int N_DIR = 24;
  localparam int N_PHASES = 20;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_REPORTS = 10;

  // region index -> amplitude bits (bit0 -> b2/b3, bit1 -> b4/b5, bit2 -> b6/b7)
  localparam logic [2:0] GRAY64 [4] = '{3'd2, 3'd0, 3'd1, 3'd3};
  localparam logic [2:0] GRAY256 [8] = '{3'd0, 3'd2, 3'd6, 3'd4, 3'd5, 3'd1, 3'd3, 3'd7};

  typedef struct packed {
    logic [BITS_W-1:0]  bits;
    logic [COUNT_W-1:0] cnt;
    logic               eob;
  } demap_res_t;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic [SAMPLE_WIDTH-1:0] si;
    logic [SAMPLE_WIDTH-1:0] sq;
    logic                    eob;
    logic                    typed;
    logic [BITS_W-1:0]       bits;
    logic [COUNT_W-1:0]      cnt;
  } dir_row_t;

  localparam dir_row_t DIRECTED [N_DIR] = '{
    '{MODE_QPSK,   16'sd32767,   16'sd32767,  1'b0, 1'b1, 8'h00, 4'd2},
    '{MODE_QPSK,   16'sh8000,    16'sh8000,   1'b1, 1'b1, 8'h03, 4'd2},
    '{MODE_QPSK,   16'sd0,       16'sd0,      1'b0, 1'b1, 8'h03, 4'd2},
    '{MODE_QPSK,   16'sd1,       -16'sd1,     1'b1, 1'b1, 8'h02, 4'd2},
    '{MODE_BPSK,   16'sd100,     -16'sd100,   1'b0, 1'b1, 8'h01, 4'd1},
    '{MODE_BPSK,   -16'sd100,    16'sd100,    1'b0, 1'b1, 8'h00, 4'd1},
    '{MODE_BPSK,   16'sd0,       16'sd0,      1'b1, 1'b1, 8'h00, 4'd1},
    '{MODE_BPSK,   16'sh8000,    16'sh8000,   1'b0, 1'b1, 8'h01, 4'd1},
    '{MODE_BPSK,   16'sd32767,   16'sd32767,  1'b0, 1'b1, 8'h00, 4'd1},
    '{MODE_BPSK,   -16'sd1,      16'sd1,      1'b1, 1'b0, 8'h00, 4'd0},
    '{MODE_QAM16,  16'sd5181,    -16'sd5181,  1'b0, 1'b1, 8'h02, 4'd4},
    '{MODE_QAM16,  16'sd5182,    -16'sd5182,  1'b1, 1'b1, 8'h0E, 4'd4},
    '{MODE_QAM16,  16'sh8000,    16'sd32767,  1'b0, 1'b0, 8'h00, 4'd0},
    '{MODE_QAM16,  -16'sd1,      16'sd1,      1'b0, 1'b0, 8'h00, 4'd0},
    '{MODE_QAM64,  16'sd0,       16'sd0,      1'b0, 1'b1, 8'h33, 4'd6},
    '{MODE_QAM64,  16'sd7585,    -16'sd7585,  1'b1, 1'b1, 8'h3E, 4'd6},
    '{MODE_QAM64,  -16'sd7584,   16'sd7584,   1'b0, 1'b1, 8'h0D, 4'd6},
    '{MODE_QAM64,  16'sd2529,    -16'sd5057,  1'b0, 1'b0, 8'h00, 4'd0},
    '{MODE_QAM256, 16'sd8793,    -16'sd8793,  1'b1, 1'b1, 8'hFE, 4'd8},
    '{MODE_QAM256, 16'sh8000,    16'sd32767,  1'b0, 1'b0, 8'h00, 4'd0},
    '{MODE_QAM256, 16'sd1256,    -16'sd1257,  1'b0, 1'b0, 8'h00, 4'd0},
    '{MODE_SPARE5, 16'sd0,       16'sd0,      1'b0, 1'b1, 8'h03, 4'd8},
    '{MODE_SPARE6, -16'sd1,      16'sd32767,  1'b0, 1'b0, 8'h00, 4'd0},
    '{MODE_SPARE7, 16'sd12000,   -16'sd2000,  1'b1, 1'b0, 8'h00, 4'd0}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_idx_e              cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  ltehdd_sym_if sym ();
  ltehdd_res_if res ();

  lte_hard_decision_demapper_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .sym_i      (sym),
    .res_o      (res)
  );

  // register mirror
  logic [MODE_W-1:0]      mode_q;
  logic [Q16_STEP_W-1:0]  st16;
  logic [Q64_STEP_W-1:0]  st64;
  logic [Q256_STEP_W-1:0] st256;

  demap_res_t pending_q [$];
  int src_pct;
  int snk_pct;
  bit hold_go;
  int hold_left;
  int err_cnt;
  int sent_cnt;
  int got_cnt;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("** lte_hard_decision_demapper_core: FAILED **");
    $finish;
  end

  function automatic demap_res_t slice_symbol(logic signed [SAMPLE_WIDTH-1:0] si,
                                              logic signed [SAMPLE_WIDTH-1:0] sq,
                                              logic eob);
    demap_res_t r;
    int vi;
    int vq;
    int mi;
    int mq;
    int ri;
    int rq;
    int stp;
    int lv;
    logic [2:0] ai;
    logic [2:0] aq;
    vi = int'(si);
    vq = int'(sq);
    mi = (vi < 0) ? -vi : vi;
    mq = (vq < 0) ? -vq : vq;
    r.eob = eob;
    r.bits = '0;
    case (mode_q)
      MODE_BPSK: begin
        r.cnt = 4'd1;
        r.bits[0] = (vi + vq < 0) || (vi + vq == 0 && vi > 0);
      end
      MODE_QPSK: begin
        r.cnt = 4'd2;
        r.bits[1:0] = {vq <= 0, vi <= 0};
      end
      default: begin
        r.bits[1:0] = {vq <= 0, vi <= 0};
        if (mode_q == MODE_QAM16) begin
          stp = int'(st16);
          lv = 1;
          r.cnt = 4'd4;
        end else if (mode_q == MODE_QAM64) begin
          stp = int'(st64);
          lv = 3;
          r.cnt = 4'd6;
        end else begin
          stp = int'(st256);
          lv = 7;
          r.cnt = 4'd8;
        end
        ri = 0;
        rq = 0;
        for (int k = 1; k <= lv; k++) begin
          if (mi > k * stp) ri++;
          if (mq > k * stp) rq++;
        end
        if (lv == 1) begin
          ai = ri[2:0];
          aq = rq[2:0];
        end else if (lv == 3) begin
          ai = GRAY64[ri];
          aq = GRAY64[rq];
        end else begin
          ai = GRAY256[ri];
          aq = GRAY256[rq];
        end
        r.bits[2] = ai[0];
        r.bits[4] = ai[1];
        r.bits[6] = ai[2];
        r.bits[3] = aq[0];
        r.bits[5] = aq[1];
        r.bits[7] = aq[2];
      end
    endcase
    return r;
  endfunction

  // biased toward the active mode's thresholds, zero and full scale
  function automatic logic [SAMPLE_WIDTH-1:0] pick_component();
    int stp;
    int lv;
    int t;
    case (mode_q)
      MODE_BPSK, MODE_QPSK, MODE_QAM16: begin
        stp = int'(st16);
        lv = 1;
      end
      MODE_QAM64: begin
        stp = int'(st64);
        lv = 3;
      end
      default: begin
        stp = int'(st256);
        lv = 7;
      end
    endcase
    case ($urandom_range(0, 3))
      0: t = $urandom;
      1: begin
        t = $urandom_range(1, lv) * stp + $urandom_range(0, 2) - 1;
        if (t < 0) t = 0;
        if (t > 32767) t = 32767;
        if ($urandom_range(0, 1)) t = -t;
      end
      2: t = $urandom_range(0, 1) ? -$urandom_range(0, 3) : $urandom_range(0, 3);
      default: t = $urandom_range(0, 1) ? -32768 : 32767;
    endcase
    return t[SAMPLE_WIDTH-1:0];
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MODE:      mode_q = data[MODE_W-1:0];
      CFG_Q16_STEP:  st16 = data[Q16_STEP_W-1:0];
      CFG_Q64_STEP:  st64 = data[Q64_STEP_W-1:0];
      CFG_Q256_STEP: st256 = data[Q256_STEP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic send_symbol(logic [SAMPLE_WIDTH-1:0] si, logic [SAMPLE_WIDTH-1:0] sq,
                             logic eob, bit typed, demap_res_t typed_res);
    while ($urandom_range(0, 99) < src_pct) begin
      sym.valid <= 1'b0;
      @(negedge clk);
    end
    sym.valid <= 1'b1;
    sym.in_i <= si;
    sym.in_q <= sq;
    sym.end_of_block <= eob;
    do @(posedge clk); while (!sym.ready);
    pending_q.push_back(typed ? typed_res : slice_symbol(si, sq, eob));
    sent_cnt++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    sym.valid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic note_error(string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
  endtask

  always @(negedge clk) begin
    if (hold_go) begin
      hold_left = HOLD_CYCLES;
      hold_go = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(0, 99) >= snk_pct);
    end
  end

  always @(posedge clk) begin
    demap_res_t want;
    if (rst_n && res.valid && res.ready) begin
      got_cnt++;
      if (pending_q.size() == 0) begin
        note_error($sformatf("unexpected item bits %02h count %0d eob %0b",
                             res.bits, res.bit_count, res.end_of_block_out));
      end else begin
        want = pending_q.pop_front();
        if (res.bits !== want.bits || res.bit_count !== want.cnt ||
            res.end_of_block_out !== want.eob) begin
          note_error($sformatf("exp bits %02h count %0d eob %0b, got bits %02h count %0d eob %0b",
                               want.bits, want.cnt, want.eob,
                               res.bits, res.bit_count, res.end_of_block_out));
        end
      end
    end
  end

  initial begin
    dir_row_t row;
    logic [SAMPLE_WIDTH-1:0] si;
    logic [SAMPLE_WIDTH-1:0] sq;
    logic [MODE_W-1:0] mode;
    int kind;
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_MODE;
    cfg_data = '0;
    sym.valid = 1'b0;
    sym.in_i = '0;
    sym.in_q = '0;
    sym.end_of_block = 1'b0;
    res.ready = 1'b0;
    src_pct = 0;
    snk_pct = 0;
    hold_go = 1'b0;
    hold_left = 0;
    err_cnt = 0;
    sent_cnt = 0;
    got_cnt = 0;
    mode_q = MODE_QPSK;
    st16 = 15'd5181;
    st64 = 14'd2528;
    st256 = 13'd1256;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: reset steps, mode switched between rows as needed
    for (int n = 0; n < N_DIR; n++) begin
      row = DIRECTED[n];
      if (row.mode != mode_q) begin
        wait_drained();
        write_reg(CFG_MODE, CFG_DATA_W'(row.mode));
      end
      send_symbol(row.si, row.sq, row.eob, row.typed, '{row.bits, row.cnt, row.eob});
    end

    for (int p = 0; p < N_PHASES; p++) begin
      wait_drained();
      mode = MODE_W'(p % 8);
      kind = p % 5;
      case (kind)
        0: begin
          write_reg(CFG_Q16_STEP, '0);
          write_reg(CFG_Q64_STEP, '0);
          write_reg(CFG_Q256_STEP, '0);
        end
        1: begin
          write_reg(CFG_Q16_STEP, 15'd32767);
          write_reg(CFG_Q64_STEP, 15'd16383);
          write_reg(CFG_Q256_STEP, 15'd8191);
        end
        2: begin
          write_reg(CFG_Q16_STEP, 15'd5181);
          write_reg(CFG_Q64_STEP, 15'd2528);
          write_reg(CFG_Q256_STEP, 15'd1256);
        end
        3: begin
          write_reg(CFG_Q16_STEP, CFG_DATA_W'($urandom_range(0, 32767)));
          write_reg(CFG_Q64_STEP, CFG_DATA_W'($urandom_range(0, 10922)));
          write_reg(CFG_Q256_STEP, CFG_DATA_W'($urandom_range(0, 4681)));
        end
        default: begin
          // junk above the 64QAM and 256QAM step register widths
          write_reg(CFG_Q16_STEP, CFG_DATA_W'($urandom_range(0, 32767)));
          write_reg(CFG_Q64_STEP, CFG_DATA_W'($urandom_range(0, 32767)));
          write_reg(CFG_Q256_STEP, CFG_DATA_W'($urandom_range(0, 32767)));
        end
      endcase
      write_reg(CFG_MODE, (kind == 4) ? (CFG_DATA_W'($urandom) & 15'h7FF8) | mode
                                       : CFG_DATA_W'(mode));
      case (p % 4)
        0: begin
          src_pct = 0;
          snk_pct = 0;
        end
        1: begin
          src_pct = 82;
          snk_pct = 0;
        end
        2: begin
          src_pct = 0;
          snk_pct = 82;
        end
        default: begin
          src_pct = 24;
          snk_pct = 24;
        end
      endcase
      if (p == 4) hold_go = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        si = pick_component();
        sq = ($urandom_range(0, 7) == 0) ? -si : pick_component();
        send_symbol(si, sq, ($urandom_range(0, 15) == 0), 1'b0, '0);
      end
    end

    wait_drained();
    if (pending_q.size() != 0) note_error("results still outstanding at end of run");
    $display("Sent %0d symbols (%0d directed) over %0d register settings, all mode codes;",
             sent_cnt, N_DIR, N_PHASES);
    $display("checked %0d results with %0d errors.", got_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("** lte_hard_decision_demapper_core: PASSED **");
    end else begin
      $display("** lte_hard_decision_demapper_core: FAILED **");
    end
    $finish;
  end

endmodule

FILE: files.f
design/ltehdd_pkg.sv
design/ltehdd_sym_if.sv
design/ltehdd_res_if.sv
design/ltehdd_slicer.sv
design/lte_hard_decision_demapper_core.sv
verif/lte_hard_decision_demapper_core_tb.sv
